FILE: sv/tpd_pkg.sv
// shared types and constants of the transport stream pid demultiplexer
`timescale 1ns / 1ps

package tpd_pkg;

  localparam int PID_SLOTS  = 16;
  localparam int SLOT_W     = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  PKT_BYTES     = 8'd188;
  localparam logic [7:0]  HDR_BYTES     = 8'd4;
  localparam logic [7:0]  SYNC_BYTE     = 8'h47;
  localparam logic [7:0]  AF_LEN_MAX    = 8'd183;
  localparam logic [7:0]  PAYLOAD_BASE  = 8'd4;
  localparam logic [7:0]  AF_DATA_BASE  = 8'd5;
  localparam logic [1:0]  AFC_PAYLOAD   = 2'b01;
  localparam logic [1:0]  AFC_BOTH      = 2'b11;
  localparam logic [19:0] UNIT_MIN_LEN  = 20'd6;
  localparam logic [19:0] LEN_MAX       = 20'hFFFFF;
  localparam logic [15:0] ERR_MAX       = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_NO_SYNC   = 3'd1,
    KIND_CC_ERROR  = 3'd2,
    KIND_AF_LONG   = 3'd3,
    KIND_UNIT_DONE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_NO_SYNC,
    OP_FULL,
    OP_CC_ERR,
    OP_HDR,
    OP_AF_LONG,
    OP_PAYLOAD
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [12:0] stream_pid;
    logic [7:0]  payload_byte;
    logic [19:0] unit_length;
    logic [15:0] error_total;
    logic        table_full;
    logic        last;
  } out_t;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [12:0]       pid;
    logic [7:0]        data;
    logic              claim;
    logic              unit;
  } cmd_t;

endpackage

FILE: sv/tpd_front.sv
// packet framing, header parse, pid table lookup and continuity check
`timescale 1ns / 1ps

module tpd_front import tpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic cmd_valid_o,
  output cmd_t cmd_o,
  input  logic cmd_ready_i
);

  logic [7:0]           pos_q, pos_d;
  logic                 drop_q, drop_d;
  logic [31:0]          hdr_q, hdr_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [7:0]           off_q, off_d;
  logic [PID_SLOTS-1:0] valid_q, valid_d;
  logic [12:0]          pid_q [PID_SLOTS];
  logic [3:0]           cnt_q [PID_SLOTS];

  logic              acc, active, drop;
  logic [7:0]        pos, b;
  logic [12:0]       pid_w;
  logic              hit, has_free;
  logic [SLOT_W-1:0] hit_idx, free_idx, wr_idx;
  logic              pid_we, cnt_we;
  logic [3:0]        cc, cnt_wdata;
  logic [1:0]        afc;
  logic              push;
  cmd_t              cmd;

  assign in_ready_o  = cmd_ready_i;
  assign acc         = in_valid_i && cmd_ready_i;
  assign b           = in_data_i.data_byte;
  assign pos         = in_data_i.packet_start ? '0 : pos_q;
  assign drop        = in_data_i.packet_start ? 1'b0 : drop_q;
  assign active      = !drop && (pos < PKT_BYTES);
  assign cc          = b[3:0];
  assign afc         = b[5:4];
  assign cnt_wdata   = cc + 4'd1;
  assign cmd_valid_o = push;
  assign cmd_o       = cmd;

  // parallel pid match, lowest slot wins
  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = PID_SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && pid_q[i] == pid_w) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    hdr_d = hdr_q;
    if (acc && active && pos < HDR_BYTES) begin
      hdr_d = {hdr_q[23:0], b};
    end
  end

  assign pid_w = {hdr_d[20:16], hdr_d[15:8]};

  always_comb begin
    pos_d   = pos_q;
    drop_d  = drop_q;
    slot_d  = slot_q;
    off_d   = off_q;
    valid_d = valid_q;
    pid_we  = 1'b0;
    cnt_we  = 1'b0;
    wr_idx  = hit_idx;
    push    = 1'b0;
    cmd     = '{op: OP_PAYLOAD, slot: slot_q, pid: pid_w, data: b, claim: 1'b0, unit: 1'b0};
    if (acc) begin
      pos_d  = pos;
      drop_d = drop;
      if (active) begin
        pos_d = pos + 8'd1;
        if (pos < HDR_BYTES) begin
          if (pos == '0 && b != SYNC_BYTE) begin
            drop_d  = 1'b1;
            push    = 1'b1;
            cmd.op  = OP_NO_SYNC;
            cmd.pid = '0;
          end else if (pos == HDR_BYTES - 8'd1) begin
            if (!hit && !has_free) begin
              drop_d = 1'b1;
              push   = 1'b1;
              cmd.op = OP_FULL;
            end else if (hit && b[4] && cnt_q[hit_idx] != cc) begin
              cnt_we   = 1'b1;
              drop_d   = 1'b1;
              push     = 1'b1;
              cmd.op   = OP_CC_ERR;
              cmd.slot = hit_idx;
            end else begin
              wr_idx    = hit ? hit_idx : free_idx;
              cnt_we    = 1'b1;
              slot_d    = wr_idx;
              cmd.op    = OP_HDR;
              cmd.slot  = wr_idx;
              cmd.claim = !hit;
              cmd.unit  = (afc == AFC_PAYLOAD) && hdr_d[22];
              push      = cmd.claim || cmd.unit;
              if (!hit) begin
                pid_we          = 1'b1;
                valid_d[wr_idx] = 1'b1;
              end
              if (!afc[0]) begin
                drop_d = 1'b1;
              end
              if (afc == AFC_PAYLOAD) begin
                off_d = PAYLOAD_BASE;
              end
            end
          end
        end else if (pos == HDR_BYTES && hdr_q[5:4] == AFC_BOTH) begin
          if (b > AF_LEN_MAX) begin
            drop_d = 1'b1;
            push   = 1'b1;
            cmd.op = OP_AF_LONG;
          end else begin
            off_d    = AF_DATA_BASE + b;
            cmd.op   = OP_HDR;
            cmd.unit = hdr_q[22];
            push     = hdr_q[22];
          end
        end else if (pos >= off_q) begin
          push   = 1'b1;
          cmd.op = OP_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      drop_q  <= 1'b1;
      hdr_q   <= '0;
      slot_q  <= '0;
      off_q   <= PAYLOAD_BASE;
      valid_q <= '0;
    end else begin
      pos_q   <= pos_d;
      drop_q  <= drop_d;
      hdr_q   <= hdr_d;
      slot_q  <= slot_d;
      off_q   <= off_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pid_we) begin
      pid_q[wr_idx] <= pid_w;
    end
    if (cnt_we) begin
      cnt_q[wr_idx] <= cnt_wdata;
    end
  end

  // slots are only ever claimed, never released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(valid_q) & ~valid_q) == '0))
    else $error("pid slot released");

  // at most one slot claimed per transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q & ~$past(valid_q)) <= 1)
    else $error("more than one slot claimed");

endmodule

FILE: sv/tpd_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps

module tpd_cmd_fifo import tpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_data_o
);

  localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o     = (cnt_q == CNT_FULL);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_FULL)
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o && !pop_i) |=> $stable(wr_q))
    else $error("write pointer moved while full");

endmodule

FILE: sv/tpd_back.sv
// per-pid unit tracking and event formation
`timescale 1ns / 1ps

module tpd_back import tpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic        col_q [PID_SLOTS];
  logic [19:0] len_q [PID_SLOTS];
  logic [15:0] err_q [PID_SLOTS];

  logic        out_valid_q, out_valid_d;
  out_t        out_q;

  logic        pop, emit, we;
  logic        col_r, col_w;
  logic [19:0] len_r, len_w;
  logic [15:0] err_r, err_w;
  out_t        ev;

  assign pop         = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o   = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    col_r = cmd_i.claim ? 1'b0 : col_q[cmd_i.slot];
    len_r = cmd_i.claim ? '0 : len_q[cmd_i.slot];
    err_r = cmd_i.claim ? '0 : err_q[cmd_i.slot];
    col_w = col_r;
    len_w = len_r;
    err_w = err_r;
    we    = 1'b0;
    emit  = 1'b0;
    ev    = '{kind: KIND_PAYLOAD, stream_pid: cmd_i.pid, payload_byte: '0,
              unit_length: '0, error_total: err_r, table_full: 1'b0, last: 1'b1};
    case (cmd_i.op)
      OP_NO_SYNC: begin
        emit           = 1'b1;
        ev.kind        = KIND_NO_SYNC;
        ev.error_total = '0;
      end
      OP_FULL: begin
        emit           = 1'b1;
        ev.kind        = KIND_CC_ERROR;
        ev.error_total = '0;
        ev.table_full  = 1'b1;
      end
      OP_CC_ERR: begin
        we             = 1'b1;
        col_w          = 1'b0;
        err_w          = (err_r == ERR_MAX) ? err_r : err_r + 16'd1;
        emit           = 1'b1;
        ev.kind        = KIND_CC_ERROR;
        ev.error_total = err_w;
      end
      OP_HDR: begin
        we = 1'b1;
        if (cmd_i.unit) begin
          if (len_r > UNIT_MIN_LEN) begin
            emit           = 1'b1;
            ev.kind        = KIND_UNIT_DONE;
            ev.unit_length = len_r;
          end
          len_w = '0;
          col_w = 1'b1;
        end
      end
      OP_AF_LONG: begin
        emit    = 1'b1;
        ev.kind = KIND_AF_LONG;
      end
      OP_PAYLOAD: begin
        if (col_r) begin
          we              = 1'b1;
          len_w           = (len_r == LEN_MAX) ? len_r : len_r + 20'd1;
          emit            = 1'b1;
          ev.kind         = KIND_PAYLOAD;
          ev.payload_byte = cmd_i.data;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      out_q <= ev;
    end
    if (pop && we) begin
      col_q[cmd_i.slot] <= col_w;
      len_q[cmd_i.slot] <= len_w;
      err_q[cmd_i.slot] <= err_w;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_UNIT_DONE) |-> (out_q.unit_length > UNIT_MIN_LEN))
    else $error("short unit reported");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.table_full) |-> (out_q.kind == KIND_CC_ERROR))
    else $error("table full flag on wrong event");

endmodule

FILE: sv/ts_packet_pid_demux_core.sv
// top level: transport stream pid demultiplexer with continuity check
// each event passes the command queue register, then the output register
// throughput: one byte per cycle while the 4-entry command queue has room;
// it decouples the pid lookup front from the per-pid unit tracking back
// reset: pid table empty, bytes ignored until the first packet start
`timescale 1ns / 1ps

module ts_packet_pid_demux_core import tpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic cmd_push, fifo_full, fifo_empty, cmd_pop;
  cmd_t cmd_in, cmd_out;

  tpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_ready_i (!fifo_full)
  );

  tpd_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (fifo_full),
    .pop_i       (cmd_pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (cmd_out)
  );

  tpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!fifo_empty),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd_out),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
